FILE: rtl/core/sbt_pkg.sv
// ---------------------------------------------------------------------------
// sbt_pkg: shared types and codes of the sorted boundary table
// Action and status codes, and the per-cell broadcast command.
// ---------------------------------------------------------------------------
package sbt_pkg;

  localparam int unsigned ACT_W  = 4;
  localparam int unsigned LAB_W  = 6;
  localparam int unsigned STAT_W = 4;
  localparam int unsigned CNT_W  = 7;

  // Configuration register indexes.
  localparam logic CFG_LEFT_END  = 1'b0;
  localparam logic CFG_RIGHT_END = 1'b1;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT    = 4'd0,
    ACT_DELETE    = 4'd1,
    ACT_MOVE      = 4'd2,
    ACT_NEAR_BLW  = 4'd3,
    ACT_POS_LAB   = 4'd4,
    ACT_NEXT_ABV  = 4'd5,
    ACT_PRED_PT   = 4'd6,
    ACT_SUCC_PT   = 4'd7,
    ACT_PRED_LAB  = 4'd8,
    ACT_SUCC_LAB  = 4'd9,
    ACT_READ_SLOT = 4'd10,
    ACT_RESTART   = 4'd11
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK          = 4'd0,
    ST_FULL        = 4'd1,
    ST_LEFT_RANGE  = 4'd2,
    ST_RIGHT_RANGE = 4'd3,
    ST_NOT_FOUND   = 4'd4,
    ST_TOO_FEW     = 4'd5,
    ST_DUP_LABEL   = 4'd6,
    ST_BAD_ARG     = 4'd7,
    ST_MAP_INVALID = 4'd8,
    ST_BAD_CONFIG  = 4'd9
  } status_t;

  // What every cell does at the end of an item.
  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_DELETE,
    CMD_MOVE,
    CMD_RESTART,
    CMD_RELABEL
  } cell_cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_DONE
  } ctl_state_t;

endpackage

FILE: rtl/core/sbt_cell.sv
// ---------------------------------------------------------------------------
// sbt_cell: one slot of the sorted boundary table
// Holds one position and label, renumbers its label on a relabel command and
// takes a new value from itself, the new value, zero, or its left or right neighbor.
// ---------------------------------------------------------------------------
module sbt_cell #(
  parameter int unsigned PW = 32
) (
  input  logic                      clk,
  input  logic                      upd,
  input  sbt_pkg::cell_cmd_t        cmd,
  input  logic                      sel_left,   // insert / move: take left neighbor
  input  logic                      sel_right,  // delete / move: take right neighbor
  input  logic                      sel_new,    // load the new value
  input  logic                      clr,        // load zero
  input  logic signed [PW-1:0]      new_pos,
  input  logic [sbt_pkg::LAB_W-1:0] new_lab,
  input  logic [sbt_pkg::LAB_W-1:0] relabel_ref,
  input  logic signed [PW-1:0]      left_pos,
  input  logic [sbt_pkg::LAB_W-1:0] left_lab,
  input  logic signed [PW-1:0]      right_pos,
  input  logic [sbt_pkg::LAB_W-1:0] right_lab,
  output logic signed [PW-1:0]      pos,
  output logic [sbt_pkg::LAB_W-1:0] lab
);

  logic signed [PW-1:0]      pos_r, pos_nxt;
  logic [sbt_pkg::LAB_W-1:0] lab_r, lab_nxt;

  always_comb begin
    pos_nxt = pos_r;
    lab_nxt = lab_r;
    if (cmd == sbt_pkg::CMD_RELABEL) begin
      if (lab_r > relabel_ref) lab_nxt = lab_r - sbt_pkg::LAB_W'(1);
    end else if (clr) begin
      pos_nxt = '0;
      lab_nxt = '0;
    end else if (sel_new) begin
      pos_nxt = new_pos;
      lab_nxt = new_lab;
    end else if (sel_left) begin
      pos_nxt = left_pos;
      lab_nxt = left_lab;
    end else if (sel_right) begin
      pos_nxt = right_pos;
      lab_nxt = right_lab;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      pos_r <= pos_nxt;
      lab_r <= lab_nxt;
    end
  end

  assign pos = pos_r;
  assign lab = lab_r;

endmodule

FILE: rtl/core/sorted_boundary_table.sv
// ---------------------------------------------------------------------------
// sorted_boundary_table: ordered map of labelled boundary points
// A row of cells keeps the points sorted by position; one controller
// evaluates an action against all cells at once and then updates the row.
// ---------------------------------------------------------------------------
//
//  Channel  Ports                         Contents
//  in       in_tvalid/in_tready/in_tdata  action, position, new_position,
//                                         label, slot
//  out      out_tvalid/out_tready/        status, result_label,
//           out_tdata                     result_position, entry_count
//  cfg      cfg_we/cfg_index/cfg_data     left_end (0), right_end (1)
//
// The cycle after acceptance is the evaluation cycle, in which every cell
// compares against the key and the action is decided. A query or a rejected
// action presents its result in the next cycle. Insert, move, restart and
// a delete that leaves the label in use spend that cycle updating the row
// before the result is presented; a successful delete also renumbers labels
// first. The next item is accepted in the cycle after the result is
// transferred. A stalled result holds the controller in its done state.
// Reset (synchronous, rst_n low) loads the two end points from the reset
// register values.
// ---------------------------------------------------------------------------
module sorted_boundary_table #(
  parameter int unsigned MAX_ENTRIES = 64,
  parameter int unsigned POS_WIDTH   = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [3:0] action, [35:4] position, [67:36] new_position,
  // [73:68] label, [79:74] slot
  input  logic [79:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [3:0] status, [9:4] result_label, [41:10] result_position,
  // [48:42] entry_count
  output logic [55:0]  out_tdata,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_data
);

  // Positions are kept at no more than 32 bits.
  localparam int unsigned PW  = (POS_WIDTH < 32) ? POS_WIDTH : 32;
  localparam int unsigned N   = MAX_ENTRIES;
  localparam int unsigned IW  = $clog2(N);
  localparam int unsigned NW  = $clog2(N + 1);
  localparam int unsigned LW  = sbt_pkg::LAB_W;

  // ---- configuration registers ----
  logic signed [31:0] left_end_r, right_end_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_end_r  <= 32'sd0;
      right_end_r <= 32'sd65536;
    end else if (cfg_we) begin
      if (cfg_index == sbt_pkg::CFG_LEFT_END) left_end_r  <= cfg_data;
      else                                    right_end_r <= cfg_data;
    end
  end

  logic signed [PW-1:0] lend, rend;
  assign lend = left_end_r[PW-1:0];
  assign rend = right_end_r[PW-1:0];

  // ---- request registers ----
  logic [3:0]           act_r;
  logic signed [PW-1:0] x_r, nx_r;
  logic [LW-1:0]        lab_r;
  logic [5:0]           slot_r;

  sbt_pkg::ctl_state_t state_r, state_nxt;
  logic [NW-1:0]       count_r, count_nxt;

  // ---- cell row ----
  logic signed [PW-1:0] pos  [N];
  logic [LW-1:0]        labv [N];
  logic                 live [N];
  logic                 sel_l [N], sel_r [N], sel_n [N], clr_c [N];
  sbt_pkg::cell_cmd_t   cmd_r;
  logic                 upd;
  logic signed [PW-1:0] cell_npos [N];
  logic [LW-1:0]        cell_nlab [N];

  // ---- per-cell compare flags (evaluated from registered request) ----
  logic le_x  [N];   // pos <= x
  logic gt_x  [N];   // pos > x
  logic eq_x  [N];
  logic eq_l  [N];
  logic lt_nx [N];   // pos < new_position
  logic gt_nx [N];

  for (genvar i = 0; i < N; i++) begin : g_cmp
    assign live[i]  = (NW'(i) < count_r);
    assign le_x[i]  = live[i] && (pos[i] <= x_r);
    assign gt_x[i]  = live[i] && (pos[i] > x_r);
    assign eq_x[i]  = live[i] && (pos[i] == x_r);
    assign eq_l[i]  = live[i] && (labv[i] == lab_r);
    assign lt_nx[i] = live[i] && (pos[i] < nx_r);
    assign gt_nx[i] = live[i] && (pos[i] > nx_r);
  end

  // First set flag of a vector (lowest index), as index plus hit.
  logic [N-1:0] f_eqx, f_eqx1, f_eql, f_eql1, f_gtx1, f_pair;
  logic [N-1:0] f_eql_nl;
  logic [IW-1:0] last_i;
  assign last_i = IW'(count_r - NW'(1));

  for (genvar i = 0; i < N; i++) begin : g_vec
    assign f_eqx[i]  = eq_x[i];
    assign f_eqx1[i] = (i >= 1) && eq_x[i];
    assign f_eql[i]  = eq_l[i];
    assign f_eql1[i] = (i >= 1) && eq_l[i];
    assign f_gtx1[i] = (i >= 1) && gt_x[i];
    assign f_eql_nl[i] = eq_l[i] && (NW'(i) + NW'(1) < count_r);
    if (i + 1 < N) begin : g_p
      assign f_pair[i] = le_x[i] && gt_x[i+1];
    end else begin : g_pl
      assign f_pair[i] = 1'b0;
    end
  end

  function automatic logic [IW:0] first_set(input logic [N-1:0] v);
    logic [IW:0] r;
    r = '0;
    for (int k = N - 1; k >= 0; k--) begin
      if (v[k]) r = {1'b1, IW'(k)};
    end
    return r;
  endfunction

  // Nearest below in a sorted table is the lowest slot holding the top
  // value at or below x: last slot with le_x, then walked to first equal.
  logic [N-1:0] f_top;
  for (genvar i = 0; i < N; i++) begin : g_top
    if (i + 1 < N) begin : g_t
      assign f_top[i] = le_x[i] && !le_x[i+1];
    end else begin : g_tl
      assign f_top[i] = le_x[i];
    end
  end

  // ---- control ----
  assign in_tready = (state_r == sbt_pkg::S_IDLE);
  logic fire_in;
  assign fire_in = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sbt_pkg::S_IDLE: if (fire_in) state_nxt = sbt_pkg::S_EVAL;
      sbt_pkg::S_EVAL: state_nxt = sbt_pkg::S_DONE;
      sbt_pkg::S_DONE: if (out_tvalid && out_tready) state_nxt = sbt_pkg::S_IDLE;
      default:         state_nxt = sbt_pkg::S_IDLE;
    endcase
  end

  // Evaluation of the item happens in S_EVAL from current cells and
  // registered compare results are not needed: decisions use flags directly
  // and are registered along with the result.
  logic [IW:0] h_eqx, h_eqx1, h_eql, h_eql1, h_gtx1, h_pair, h_eqlnl, h_top;
  assign h_eqx   = first_set(f_eqx);
  assign h_eqx1  = first_set(f_eqx1);
  assign h_eql   = first_set(f_eql);
  assign h_eql1  = first_set(f_eql1);
  assign h_gtx1  = first_set(f_gtx1);
  assign h_pair  = first_set(f_pair);
  assign h_eqlnl = first_set(f_eql_nl);
  assign h_top   = first_set(f_top);

  // Lowest slot equal to the top value: first slot whose pos equals that.
  logic [N-1:0] f_eqtop;
  for (genvar i = 0; i < N; i++) begin : g_eqt
    assign f_eqtop[i] = live[i] && (pos[i] == pos[h_top[IW-1:0]]);
  end
  logic [IW:0] h_nb;
  assign h_nb = first_set(f_eqtop);

  // ---- decision (S_EVAL) ----
  sbt_pkg::status_t     st;
  logic [LW-1:0]        rl;
  logic signed [PW-1:0] rp;
  sbt_pkg::cell_cmd_t   cmd;
  logic [IW-1:0]        tgt;      // insert / delete / move slot
  logic [IW-1:0]        dest;     // move destination
  logic                 hit;
  logic [IW-1:0]        hs;
  logic                 rl_pending; // delete needs a relabel cycle
  logic [IW:0]          h_ins;
  logic                 del_dup;
  logic                 mv_down;
  logic [IW:0]          h_dn, h_up;
  logic [N-1:0]         f_dn, f_up;

  // Move: destination after bubbling. Down: first slot j in [0,tgt) with
  // pos[j] > nx (bubble stops once not below); up: last slot j in (tgt,last]
  // with pos[j] < nx.
  for (genvar i = 0; i < N; i++) begin : g_mv
    assign f_dn[i] = gt_nx[i] && (IW'(i) < h_eqx1[IW-1:0]);
    if (i + 1 < N) begin : g_u
      assign f_up[i] = (IW'(i) > h_eqx1[IW-1:0]) && lt_nx[i]
                    && !(lt_nx[i+1] && (IW'(i+1) > h_eqx1[IW-1:0]));
    end else begin : g_ul
      assign f_up[i] = (IW'(i) > h_eqx1[IW-1:0]) && lt_nx[i];
    end
  end
  assign h_dn = first_set(f_dn);
  assign h_up = first_set(f_up);

  always_comb begin
    st = sbt_pkg::ST_NOT_FOUND;
    rl = '0;
    rp = '0;
    cmd = sbt_pkg::CMD_HOLD;
    tgt = '0;
    dest = '0;
    hit = 1'b0;
    hs = '0;
    rl_pending = 1'b0;
    h_ins = h_gtx1;
    del_dup = 1'b0;
    mv_down = (nx_r < x_r);
    unique case (act_r)
      sbt_pkg::ACT_INSERT: begin
        if (count_r >= NW'(N)) st = sbt_pkg::ST_FULL;
        else if (x_r <= pos[0]) st = sbt_pkg::ST_LEFT_RANGE;
        else if (x_r >= pos[last_i]) st = sbt_pkg::ST_RIGHT_RANGE;
        else begin
          st = sbt_pkg::ST_OK;
          cmd = sbt_pkg::CMD_INSERT;
          tgt = h_ins[IW-1:0];
        end
      end
      sbt_pkg::ACT_DELETE: begin
        if (count_r <= NW'(2)) st = sbt_pkg::ST_TOO_FEW;
        else if (h_eqx[IW]) begin
          cmd = sbt_pkg::CMD_DELETE;
          tgt = h_eqx[IW-1:0];
          // Another live slot besides the removed one still carries the label.
          del_dup = (f_eql & ~(N'(1) << h_eqx[IW-1:0])) != '0;
          if (del_dup) st = sbt_pkg::ST_DUP_LABEL;
          else begin
            st = sbt_pkg::ST_OK;      // refined in the relabel cycle
            rl_pending = 1'b1;
          end
        end
      end
      sbt_pkg::ACT_MOVE: begin
        if (h_eqx1[IW]) begin
          st = sbt_pkg::ST_OK;
          cmd = sbt_pkg::CMD_MOVE;
          tgt = h_eqx1[IW-1:0];
          if (mv_down) dest = h_dn[IW] ? h_dn[IW-1:0] : tgt;
          else         dest = h_up[IW] ? h_up[IW-1:0] : tgt;
        end
      end
      sbt_pkg::ACT_NEAR_BLW: begin
        hit = h_top[IW];
        hs = h_nb[IW-1:0];
      end
      sbt_pkg::ACT_POS_LAB: begin
        hit = h_eql[IW];
        hs = h_eql[IW-1:0];
      end
      sbt_pkg::ACT_NEXT_ABV: begin
        hit = h_gtx1[IW];
        hs = h_gtx1[IW-1:0];
      end
      sbt_pkg::ACT_PRED_PT: begin
        if (x_r >= pos[last_i]) begin
          st = sbt_pkg::ST_OK;
          rl = LW'(1);
          rp = pos[last_i];
        end else begin
          hit = h_pair[IW];
          hs = h_pair[IW-1:0];
        end
      end
      sbt_pkg::ACT_SUCC_PT: begin
        hit = h_pair[IW];
        hs = h_pair[IW-1:0] + IW'(1);
      end
      sbt_pkg::ACT_PRED_LAB: begin
        if (lab_r == '0) st = sbt_pkg::ST_BAD_ARG;
        else begin
          hit = h_eql1[IW];
          hs = h_eql1[IW-1:0] - IW'(1);
        end
      end
      sbt_pkg::ACT_SUCC_LAB: begin
        if (lab_r == LW'(1)) st = sbt_pkg::ST_BAD_ARG;
        else begin
          hit = h_eqlnl[IW];
          hs = h_eqlnl[IW-1:0] + IW'(1);
        end
      end
      sbt_pkg::ACT_READ_SLOT: begin
        if (NW'(slot_r) >= count_r) st = sbt_pkg::ST_BAD_ARG;
        else begin
          hit = 1'b1;
          hs = IW'(slot_r);
        end
      end
      sbt_pkg::ACT_RESTART: begin
        if (lend >= rend) st = sbt_pkg::ST_BAD_CONFIG;
        else begin
          st = sbt_pkg::ST_OK;
          cmd = sbt_pkg::CMD_RESTART;
        end
      end
      default: st = sbt_pkg::ST_BAD_ARG;
    endcase
    if (hit) begin
      st = sbt_pkg::ST_OK;
      rl = labv[hs];
      rp = pos[hs];
    end
  end

  // ---- update bookkeeping ----
  logic [IW-1:0] tgt_r, dest_r;
  logic          down_r, relab_r;
  sbt_pkg::status_t st_r;
  logic [LW-1:0]    rl_r;
  logic signed [PW-1:0] rp_r;

  always_comb begin
    count_nxt = count_r;
    if (state_r == sbt_pkg::S_EVAL) begin
      unique case (cmd)
        sbt_pkg::CMD_INSERT:  count_nxt = count_r + NW'(1);
        sbt_pkg::CMD_DELETE:  count_nxt = count_r - NW'(1);
        sbt_pkg::CMD_RESTART: count_nxt = NW'(2);
        default:              count_nxt = count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sbt_pkg::S_IDLE;
      count_r <= NW'(2);
      cmd_r   <= sbt_pkg::CMD_RESTART;
      relab_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (state_r == sbt_pkg::S_EVAL) begin
        cmd_r   <= cmd;
        relab_r <= rl_pending;
      end else if (cmd_r == sbt_pkg::CMD_DELETE && relab_r) begin
        cmd_r   <= sbt_pkg::CMD_RELABEL;
        relab_r <= 1'b0;
      end else begin
        cmd_r   <= sbt_pkg::CMD_HOLD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire_in) begin
      act_r  <= in_tdata[3:0];
      x_r    <= in_tdata[4 +: PW];
      nx_r   <= in_tdata[36 +: PW];
      lab_r  <= in_tdata[73:68];
      slot_r <= in_tdata[79:74];
    end
    if (state_r == sbt_pkg::S_EVAL) begin
      tgt_r  <= tgt;
      dest_r <= dest;
      down_r <= mv_down;
      st_r   <= st;
      rl_r   <= rl;
      rp_r   <= rp;
    end
  end

  // Cells update the cycle after evaluation (cmd_r), and a delete that frees
  // its label then renumbers labels. The map check of a delete runs on
  // the renumbered row while the result waits.
  assign upd = (cmd_r != sbt_pkg::CMD_HOLD);

  for (genvar i = 0; i < N; i++) begin : g_sel
    always_comb begin
      sel_l[i] = 1'b0;
      sel_r[i] = 1'b0;
      sel_n[i] = 1'b0;
      clr_c[i] = 1'b0;
      cell_npos[i] = nx_r;
      cell_nlab[i] = lab_r;
      unique case (cmd_r)
        sbt_pkg::CMD_INSERT: begin
          cell_npos[i] = x_r;
          if (IW'(i) == tgt_r) sel_n[i] = 1'b1;
          else if (IW'(i) > tgt_r) sel_l[i] = 1'b1;
        end
        sbt_pkg::CMD_DELETE: begin
          if (NW'(i) == count_r) clr_c[i] = 1'b1;
          else if (IW'(i) >= tgt_r) sel_r[i] = 1'b1;
        end
        sbt_pkg::CMD_MOVE: begin
          cell_nlab[i] = labv[tgt_r];
          if (IW'(i) == dest_r) sel_n[i] = 1'b1;
          else if (down_r && IW'(i) > dest_r && IW'(i) <= tgt_r) sel_l[i] = 1'b1;
          else if (!down_r && IW'(i) >= tgt_r && IW'(i) < dest_r) sel_r[i] = 1'b1;
        end
        sbt_pkg::CMD_RESTART: begin
          if (i == 0) begin
            sel_n[i] = 1'b1;
            cell_npos[i] = lend;
            cell_nlab[i] = '0;
          end else if (i == 1) begin
            sel_n[i] = 1'b1;
            cell_npos[i] = rend;
            cell_nlab[i] = LW'(1);
          end else begin
            clr_c[i] = 1'b1;
          end
        end
        default: ;
      endcase
    end

    if (i == 0) begin : g_c0
      sbt_cell #(.PW(PW)) u_cell (
        .clk, .upd, .cmd(cmd_r),
        .sel_left(1'b0), .sel_right(sel_r[i]), .sel_new(sel_n[i]),
        .clr(clr_c[i]), .new_pos(cell_npos[i]), .new_lab(cell_nlab[i]),
        .relabel_ref(lab_r),
        .left_pos(pos[i]), .left_lab(labv[i]),
        .right_pos(pos[(i+1) % N]), .right_lab(labv[(i+1) % N]),
        .pos(pos[i]), .lab(labv[i])
      );
    end else if (i == N - 1) begin : g_cn
      sbt_cell #(.PW(PW)) u_cell (
        .clk, .upd, .cmd(cmd_r),
        .sel_left(sel_l[i]), .sel_right(1'b0), .sel_new(sel_n[i]),
        .clr(clr_c[i]), .new_pos(cell_npos[i]), .new_lab(cell_nlab[i]),
        .relabel_ref(lab_r),
        .left_pos(pos[i-1]), .left_lab(labv[i-1]),
        .right_pos(pos[i]), .right_lab(labv[i]),
        .pos(pos[i]), .lab(labv[i])
      );
    end else begin : g_cm
      sbt_cell #(.PW(PW)) u_cell (
        .clk, .upd, .cmd(cmd_r),
        .sel_left(sel_l[i]), .sel_right(sel_r[i]), .sel_new(sel_n[i]),
        .clr(clr_c[i]), .new_pos(cell_npos[i]), .new_lab(cell_nlab[i]),
        .relabel_ref(lab_r),
        .left_pos(pos[i-1]), .left_lab(labv[i-1]),
        .right_pos(pos[i+1]), .right_lab(labv[i+1]),
        .pos(pos[i]), .lab(labv[i])
      );
    end
  end

  // Map check after a delete: end labels and non-descending positions.
  logic [N-1:0] desc;
  for (genvar i = 0; i < N; i++) begin : g_desc
    if (i >= 1) begin : g_d
      assign desc[i] = live[i] && (pos[i] < pos[i-1]);
    end else begin : g_d0
      assign desc[i] = 1'b0;
    end
  end
  logic map_ok;
  assign map_ok = (labv[0] == '0) && (labv[last_i] == LW'(1)) && (desc == '0);

  // The result is valid once the row has settled (no update pending).
  logic is_del_ok;
  assign is_del_ok = (act_r == sbt_pkg::ACT_DELETE) && (st_r == sbt_pkg::ST_OK);
  assign out_tvalid = (state_r == sbt_pkg::S_DONE) && (cmd_r == sbt_pkg::CMD_HOLD);

  sbt_pkg::status_t st_out;
  assign st_out = (is_del_ok && !map_ok) ? sbt_pkg::ST_MAP_INVALID : st_r;

  logic signed [31:0] rp_ext;
  assign rp_ext = 32'(rp_r);

  assign out_tdata = {7'd0, count_r, rp_ext, rl_r, st_out};

endmodule
